/* hdl/svmlr_pkg.sv */
// Shared types, codes, constants and the 2^-k/16 table for the SVM predictor.
// No dependencies; svm_linear_rbf_predict, svmlr_div and svmlr_checker import this package.
package svmlr_pkg;

    localparam int MAX_DIM_DEF     = 256;
    localparam int MAX_VECTORS_DEF = 64;
    localparam int PADDR_W         = 5;

    localparam logic [30:0] GAMMA_RESET     = 31'd65536;
    localparam logic [8:0]  DIM_COUNT_RESET = 9'd256;
    localparam logic [16:0] LOG2E_Q16       = 17'd94548;
    localparam logic [24:0] EXP_T_CAP       = 25'h100_0000;
    localparam logic signed [63:0] F_MAX    = 64'sd2147483647;
    localparam logic signed [63:0] F_MIN    = -64'sd2147483648;

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_SUPPORT = 2'd1,
        CMD_ALPHA   = 2'd2,
        CMD_FEATURE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_KERNEL_MODE     = 3'd0,
        REG_BIAS            = 3'd1,
        REG_SIGMOID_SLOPE   = 3'd2,
        REG_SIGMOID_OFFSET  = 3'd3,
        REG_KERNEL_GAMMA    = 3'd4,
        REG_VECTOR_COUNT    = 3'd5,
        REG_DIMENSION_COUNT = 3'd6
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE,
        ST_LIN_RD, ST_LIN_MUL, ST_LIN_ACC,
        ST_RBF_RD, ST_RBF_SQ, ST_RBF_ACC,
        ST_GAM_LO, ST_GAM_HI, ST_GAM_SUM,
        ST_EXP_U, ST_EXP_SEG, ST_EXP_V,
        ST_ALPHA_MUL, ST_ALPHA_ACC,
        ST_BIAS, ST_SIG_MUL, ST_SIG_Z,
        ST_DIV_GO, ST_DIV_WAIT, ST_OUT, ST_FCLR
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [5:0]         vector_index;
        logic [7:0]         dim_index;
        logic signed [31:0] value;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [15:0]        score;
        logic               label_positive;
        logic signed [31:0] decision_value;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // round(65536 * 2^(-k/16)), k = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

/* hdl/svm_linear_rbf_predict.sv */
// SVM predictor, linear or radial basis kernel, Platt sigmoid score, Q16.16.
// Load and feature words: one per cycle while idle; no word is taken during an evaluation
// or a clearing sweep. A last feature word starts an evaluation, linear or radial,
// bound by the one shared multiplier and the divider; then a sweep clears the
// feature store. Reset is asynchronous; after it a sweep clears weight and
// feature stores before the first word is taken.
module svm_linear_rbf_predict #(
    parameter int MAX_DIM     = svmlr_pkg::MAX_DIM_DEF,
    parameter int MAX_VECTORS = svmlr_pkg::MAX_VECTORS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  svmlr_pkg::item_t              item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output svmlr_pkg::result_t            result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svmlr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import svmlr_pkg::*;

    localparam int DIM_AW = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
    localparam int DIM_CW = $clog2(MAX_DIM + 1);
    localparam int VEC_AW = MAX_VECTORS > 1 ? $clog2(MAX_VECTORS) : 1;
    localparam int VEC_CW = $clog2(MAX_VECTORS + 1);
    localparam int SV_DEPTH = MAX_VECTORS * MAX_DIM;
    localparam int SV_AW  = SV_DEPTH > 1 ? $clog2(SV_DEPTH) : 1;

    // ---------------- configuration registers ----------------
    logic               kernel_mode_reg;
    logic signed [31:0] bias_reg;
    logic signed [31:0] sigmoid_slope_reg;
    logic signed [31:0] sigmoid_offset_reg;
    logic [30:0]        kernel_gamma_reg;
    logic [6:0]         vector_count_reg;
    logic [8:0]         dimension_count_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg     <= 1'b0;
            bias_reg            <= '0;
            sigmoid_slope_reg   <= '0;
            sigmoid_offset_reg  <= '0;
            kernel_gamma_reg    <= GAMMA_RESET;
            vector_count_reg    <= '0;
            dimension_count_reg <= DIM_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_KERNEL_MODE:     kernel_mode_reg     <= pwdata[0];
                REG_BIAS:            bias_reg            <= pwdata;
                REG_SIGMOID_SLOPE:   sigmoid_slope_reg   <= pwdata;
                REG_SIGMOID_OFFSET:  sigmoid_offset_reg  <= pwdata;
                REG_KERNEL_GAMMA:    kernel_gamma_reg    <= pwdata[30:0];
                REG_VECTOR_COUNT:    vector_count_reg    <= pwdata[6:0];
                REG_DIMENSION_COUNT: dimension_count_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_KERNEL_MODE:     prdata = {31'b0, kernel_mode_reg};
            REG_BIAS:            prdata = bias_reg;
            REG_SIGMOID_SLOPE:   prdata = sigmoid_slope_reg;
            REG_SIGMOID_OFFSET:  prdata = sigmoid_offset_reg;
            REG_KERNEL_GAMMA:    prdata = {1'b0, kernel_gamma_reg};
            REG_VECTOR_COUNT:    prdata = {25'b0, vector_count_reg};
            REG_DIMENSION_COUNT: prdata = {23'b0, dimension_count_reg};
            default:             prdata = '0;
        endcase
    end

    // Clamp the counts to what the stores hold.
    logic [DIM_CW-1:0] dims_eff;
    logic [VEC_CW-1:0] vecs_eff;
    logic [DIM_AW-1:0] dim_last;
    logic [VEC_AW-1:0] vec_last;

    always_comb
    begin
        if (32'(dimension_count_reg) > 32'(MAX_DIM))
            dims_eff = DIM_CW'(MAX_DIM);
        else
            dims_eff = DIM_CW'(dimension_count_reg);
        if (32'(vector_count_reg) > 32'(MAX_VECTORS))
            vecs_eff = VEC_CW'(MAX_VECTORS);
        else
            vecs_eff = VEC_CW'(vector_count_reg);
        dim_last = DIM_AW'(dims_eff - 1'b1);
        vec_last = VEC_AW'(vecs_eff - 1'b1);
    end

    // ---------------- sequencer state ----------------
    state_t              state_reg,  state_next;
    logic [DIM_AW-1:0]   d_reg,      d_next;
    logic [VEC_AW-1:0]   j_reg,      j_next;
    logic [SV_AW-1:0]    row_reg,    row_next;
    logic signed [63:0]  acc_reg,    acc_next;
    logic [63:0]         dist_reg,   dist_next;
    logic [62:0]         plo_reg,    plo_next;
    logic [24:0]         t_reg,      t_next;
    logic [4:0]          n_reg,      n_next;
    logic                ez_reg,     ez_next;
    logic [16:0]         hi_reg,     hi_next;
    logic [16:0]         e_reg,      e_next;
    logic signed [31:0]  f_reg,      f_next;
    logic                neg_reg,    neg_next;
    logic                ret_sig_reg, ret_sig_next;
    logic [15:0]         score_reg,  score_next;
    result_t             result_reg, result_next;
    logic                rvalid_reg, rvalid_next;

    // ---------------- stores ----------------
    logic              accept;
    logic              di_ok, vi_ok;
    logic              w_we, f_we, s_we, a_we;
    logic [DIM_AW-1:0] w_waddr, f_waddr;
    logic [31:0]       w_wdata, f_wdata;
    logic [31:0]       weight_q, feat_q, sv_q, alpha_q;
    logic [SV_AW-1:0]  s_waddr, s_raddr;

    assign accept = item_valid & item_ready;
    assign di_ok  = 32'(item.dim_index) < 32'(MAX_DIM);
    assign vi_ok  = 32'(item.vector_index) < 32'(MAX_VECTORS);
    assign s_waddr = SV_AW'(32'(item.vector_index) * 32'(MAX_DIM) + 32'(item.dim_index));
    assign s_raddr = row_reg + SV_AW'(d_reg);
    assign s_we   = accept && cmd_t'(item.cmd) == CMD_SUPPORT && vi_ok && di_ok;
    assign a_we   = accept && cmd_t'(item.cmd) == CMD_ALPHA && vi_ok;

    // Clearing sweeps take the write ports; otherwise loads drive them.
    always_comb
    begin
        w_we    = accept && cmd_t'(item.cmd) == CMD_WEIGHT && di_ok;
        w_waddr = DIM_AW'(item.dim_index);
        w_wdata = item.value;
        f_we    = accept && cmd_t'(item.cmd) == CMD_FEATURE && di_ok;
        f_waddr = DIM_AW'(item.dim_index);
        f_wdata = item.value;
        if (state_reg == ST_INIT)
        begin
            w_we    = 1'b1;
            w_waddr = d_reg;
            w_wdata = '0;
        end
        if (state_reg == ST_INIT || state_reg == ST_FCLR)
        begin
            f_we    = 1'b1;
            f_waddr = d_reg;
            f_wdata = '0;
        end
    end

    svmlr_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(d_reg), .rdata(weight_q)
    );

    svmlr_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_feature (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(d_reg), .rdata(feat_q)
    );

    svmlr_ram #(.WIDTH(32), .DEPTH(SV_DEPTH)) u_support (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(item.value),
        .raddr(s_raddr), .rdata(sv_q)
    );

    svmlr_ram #(.WIDTH(32), .DEPTH(MAX_VECTORS)) u_alpha (
        .clk(clk), .we(a_we), .waddr(VEC_AW'(item.vector_index)), .wdata(item.value),
        .raddr(j_reg), .rdata(alpha_q)
    );

    // ---------------- shared multiplier ----------------
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [32:0] diff;
    logic [32:0]        mag;

    svmlr_mul #(.OW(34)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

    always_comb
    begin
        diff = {feat_q[31], feat_q} - {sv_q[31], sv_q};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LIN_MUL:
            begin
                mul_a = {{2{weight_q[31]}}, weight_q};
                mul_b = {{2{feat_q[31]}}, feat_q};
            end
            ST_RBF_SQ:
            begin
                mul_a = {1'b0, mag};
                mul_b = {1'b0, mag};
            end
            ST_GAM_LO:
            begin
                mul_a = {3'b0, kernel_gamma_reg};
                mul_b = {2'b0, dist_reg[31:0]};
            end
            ST_GAM_HI:
            begin
                mul_a = {3'b0, kernel_gamma_reg};
                mul_b = {2'b0, dist_reg[63:32]};
            end
            ST_EXP_U:
            begin
                mul_a = {9'b0, t_reg};
                mul_b = {17'b0, LOG2E_Q16};
            end
            ST_EXP_SEG:
            begin
                // interpolation step between neighboring table points
                mul_a = {17'b0, 17'(pow2_neg({1'b0, prod[31:28]})
                                   - pow2_neg({1'b0, prod[31:28]} + 5'd1))};
                mul_b = {22'b0, prod[27:16]};
            end
            ST_ALPHA_MUL:
            begin
                mul_a = {{2{alpha_q[31]}}, alpha_q};
                mul_b = {17'b0, e_reg};
            end
            ST_SIG_MUL:
            begin
                mul_a = {{2{sigmoid_slope_reg[31]}}, sigmoid_slope_reg};
                mul_b = {{2{f_reg[31]}}, f_reg};
            end
            default: ;
        endcase
    end

    // ---------------- divider for the sigmoid ----------------
    logic        div_start;
    logic [32:0] div_num;
    logic [17:0] div_den;
    logic [32:0] div_quo;
    div_status_t div_sts;

    assign div_start = state_reg == ST_DIV_GO;
    // z >= 0: e*2^16/(2^16+e); z < 0: 2^32/(2^16+e)
    assign div_num = neg_reg ? 33'h1_0000_0000 : {e_reg, 16'b0};
    assign div_den = 18'h1_0000 + {1'b0, e_reg};

    svmlr_div #(.NW(33), .DW(18)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(div_num), .den(div_den), .quo(div_quo), .status(div_sts)
    );

    // ---------------- sequencer ----------------
    logic [94:0]        gprod;
    logic [78:0]        t_full;
    logic signed [63:0] fsum;
    logic signed [48:0] z;
    logic [48:0]        zmag;
    logic [16:0]        v;

    always_comb
    begin
        gprod  = {prod[62:0], 32'b0} + {32'b0, plo_reg};
        t_full = gprod[94:16];
        fsum   = acc_reg + {{32{bias_reg[31]}}, bias_reg};
        z      = {prod[63], prod[63:16]} + {{17{sigmoid_offset_reg[31]}}, sigmoid_offset_reg};
        zmag   = z[48] ? 49'(-z) : 49'(z);
        v      = hi_reg - {5'b0, prod[23:12]};
    end

    always_comb
    begin
        state_next   = state_reg;
        d_next       = d_reg;
        j_next       = j_reg;
        row_next     = row_reg;
        acc_next     = acc_reg;
        dist_next    = dist_reg;
        plo_next     = plo_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        ez_next      = ez_reg;
        hi_next      = hi_reg;
        e_next       = e_reg;
        f_next       = f_reg;
        neg_next     = neg_reg;
        ret_sig_next = ret_sig_reg;
        score_next   = score_reg;
        result_next  = result_reg;
        rvalid_next  = rvalid_reg && !result_ready;

        case (state_reg)
            ST_INIT, ST_FCLR:
            begin
                // advance the clearing sweep over every entry
                d_next = d_reg + 1'b1;
                if (d_reg == DIM_AW'(MAX_DIM - 1))
                begin
                    d_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && cmd_t'(item.cmd) == CMD_FEATURE && item.last)
                begin
                    d_next    = '0;
                    j_next    = '0;
                    row_next  = '0;
                    acc_next  = '0;
                    dist_next = '0;
                    if (!kernel_mode_reg)
                        state_next = (dims_eff == '0) ? ST_BIAS : ST_LIN_RD;
                    else if (vecs_eff == '0)
                        state_next = ST_BIAS;
                    else
                        state_next = (dims_eff == '0) ? ST_GAM_LO : ST_RBF_RD;
                end
            end
            ST_LIN_RD:  state_next = ST_LIN_MUL;
            ST_LIN_MUL: state_next = ST_LIN_ACC;
            ST_LIN_ACC:
            begin
                acc_next = acc_reg + {{16{prod[63]}}, prod[63:16]};
                if (d_reg == dim_last)
                    state_next = ST_BIAS;
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = ST_LIN_RD;
                end
            end
            ST_RBF_RD: state_next = ST_RBF_SQ;
            ST_RBF_SQ: state_next = ST_RBF_ACC;
            ST_RBF_ACC:
            begin
                dist_next = dist_reg + {16'b0, prod[63:16]};
                if (d_reg == dim_last)
                    state_next = ST_GAM_LO;
                else
                begin
                    d_next     = d_reg + 1'b1;
                    state_next = ST_RBF_RD;
                end
            end
            ST_GAM_LO: state_next = ST_GAM_HI;
            ST_GAM_HI:
            begin
                plo_next   = prod[62:0];
                state_next = ST_GAM_SUM;
            end
            ST_GAM_SUM:
            begin
                // cap at 256.0; this also covers the 64-bit overflow case
                t_next       = (t_full > {54'b0, EXP_T_CAP}) ? EXP_T_CAP : t_full[24:0];
                ret_sig_next = 1'b0;
                state_next   = ST_EXP_U;
            end
            ST_EXP_U: state_next = ST_EXP_SEG;
            ST_EXP_SEG:
            begin
                n_next     = prod[36:32];
                ez_next    = prod[41:32] > 10'd16;
                hi_next    = pow2_neg({1'b0, prod[31:28]});
                state_next = ST_EXP_V;
            end
            ST_EXP_V:
            begin
                e_next     = ez_reg ? 17'd0 : (v >> n_reg);
                state_next = ret_sig_reg ? ST_DIV_GO : ST_ALPHA_MUL;
            end
            ST_ALPHA_MUL: state_next = ST_ALPHA_ACC;
            ST_ALPHA_ACC:
            begin
                acc_next = acc_reg + {{16{prod[63]}}, prod[63:16]};
                if (j_reg == vec_last)
                    state_next = ST_BIAS;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    row_next   = row_reg + SV_AW'(MAX_DIM);
                    d_next     = '0;
                    dist_next  = '0;
                    state_next = (dims_eff == '0) ? ST_GAM_LO : ST_RBF_RD;
                end
            end
            ST_BIAS:
            begin
                if (fsum > F_MAX)
                    f_next = 32'sh7FFF_FFFF;
                else if (fsum < F_MIN)
                    f_next = 32'sh8000_0000;
                else
                    f_next = fsum[31:0];
                state_next = ST_SIG_MUL;
            end
            ST_SIG_MUL: state_next = ST_SIG_Z;
            ST_SIG_Z:
            begin
                neg_next     = z[48];
                t_next       = (zmag > {24'b0, EXP_T_CAP}) ? EXP_T_CAP : zmag[24:0];
                ret_sig_next = 1'b1;
                state_next   = ST_EXP_U;
            end
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    score_next = (div_quo > 33'd65535) ? 16'hFFFF : div_quo[15:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!rvalid_reg || result_ready)
                begin
                    result_next.score          = score_reg;
                    result_next.label_positive = !f_reg[31];
                    result_next.decision_value = f_reg;
                    rvalid_next                = 1'b1;
                    d_next                     = '0;
                    state_next                 = ST_FCLR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            d_reg       <= '0;
            j_reg       <= '0;
            row_reg     <= '0;
            acc_reg     <= '0;
            dist_reg    <= '0;
            plo_reg     <= '0;
            t_reg       <= '0;
            n_reg       <= '0;
            ez_reg      <= 1'b0;
            hi_reg      <= '0;
            e_reg       <= '0;
            f_reg       <= '0;
            neg_reg     <= 1'b0;
            ret_sig_reg <= 1'b0;
            score_reg   <= '0;
            result_reg  <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            d_reg       <= d_next;
            j_reg       <= j_next;
            row_reg     <= row_next;
            acc_reg     <= acc_next;
            dist_reg    <= dist_next;
            plo_reg     <= plo_next;
            t_reg       <= t_next;
            n_reg       <= n_next;
            ez_reg      <= ez_next;
            hi_reg      <= hi_next;
            e_reg       <= e_next;
            f_reg       <= f_next;
            neg_reg     <= neg_next;
            ret_sig_reg <= ret_sig_next;
            score_reg   <= score_next;
            result_reg  <= result_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    assign item_ready   = state_reg == ST_IDLE;
    assign result_valid = rvalid_reg;
    assign result       = result_reg;
endmodule

/* hdl/svmlr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svmlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/svmlr_mul.sv */
// Shared signed multiplier with a registered product.
// No dependencies.
module svmlr_mul #(
    parameter int OW = 34
) (
    input  logic                   clk,
    input  logic signed [OW-1:0]   a,
    input  logic signed [OW-1:0]   b,
    output logic signed [2*OW-1:0] p
);
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule

/* hdl/svmlr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on svmlr_pkg for the status struct.
module svmlr_div #(
    parameter int NW = 33,
    parameter int DW = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NW-1:0]            num,
    input  logic [DW-1:0]            den,
    output logic [NW-1:0]            quo,
    output svmlr_pkg::div_status_t   status
);
    import svmlr_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            cnt_reg  <= CW'(NW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quo         = num_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule

/* hdl/svmlr_checker.sv */
// Port-level assertions for the SVM predictor, bound to the top level.
// Depends on svmlr_pkg.
module svmlr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input svmlr_pkg::item_t    item,
    input logic                result_valid,
    input logic                result_ready,
    input svmlr_pkg::result_t  result
);
    import svmlr_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result word changed while stalled");

    a_label_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.label_positive == !result.decision_value[31])
        else $error("label disagrees with decision sign");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.cmd == CMD_FEATURE && item.last |=> !item_ready)
        else $error("input taken during evaluation");
endmodule

bind svm_linear_rbf_predict svmlr_checker u_svmlr_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for svm_linear_rbf_predict: directed table then random load/feature words.
// Depends on hdl/svmlr_pkg.sv and hdl/svm_linear_rbf_predict.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svmlr_pkg::*;

    localparam int     DIMS      = MAX_DIM_DEF;
    localparam int     VECS      = MAX_VECTORS_DEF;
    localparam int     LIMIT     = 10000000;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    // round(65536 * 2^(-k/16)), own copy for the score predictor
    localparam longint POW2_TAB [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    svm_linear_rbf_predict u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow copy of the block's memories and registers.
    logic signed [31:0] weight_mem  [DIMS];
    logic signed [31:0] sv_mem      [VECS*DIMS];
    logic signed [31:0] alpha_mem   [VECS];
    logic signed [31:0] feature_mem [DIMS];
    logic               kmode;
    longint             bias_q, slope_q, offset_q;
    logic [30:0]        gamma_q;
    logic [6:0]         vcount;
    logic [8:0]         dcount;

    // Expected results waiting for the output side, and per-word typed expectations
    // queued by the sender in offer order.
    typedef struct {
        bit      typed;
        result_t res;
    } offer_t;

    result_t  expected_results [$];
    offer_t   offered_words [$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_cycles = 0;

    // exp(-t), t and result Q16.16, interpolated 2^-x table
    function automatic logic [63:0] exp_neg_q(input logic [63:0] t_in);
        logic [63:0] t, u, n, r;
        longint      hi, lo, v;
        t = t_in;
        if (t > 64'h100_0000)
            t = 64'h100_0000;
        u = (t * 64'd94548) >> 16;
        n = u >> 16;
        if (n > 16)
            return 64'd0;
        r  = u & 64'hFFFF;
        hi = POW2_TAB[r[15:12]];
        lo = POW2_TAB[r[15:12] + 1];
        v  = hi - (((hi - lo) * longint'(r[11:0])) >>> 12);
        return 64'(v) >> n;
    endfunction

    function automatic logic [15:0] platt_score(input longint f);
        longint      z;
        logic [63:0] e, s;
        z = ((slope_q * f) >>> 16) + offset_q;
        if (z >= 0)
        begin
            e = exp_neg_q(64'(z));
            s = (e << 16) / (64'd65536 + e);
        end
        else
        begin
            e = exp_neg_q(64'(-z));
            s = (64'd1 << 32) / (64'd65536 + e);
        end
        if (s > 64'd65535)
            s = 64'd65535;
        return s[15:0];
    endfunction

    function automatic longint decision_value();
        int          nd, nv;
        longint      acc, diff;
        logic [63:0] dist2, mag, t, k;
        nd  = (dcount > DIMS) ? DIMS : int'(dcount);
        nv  = (vcount > VECS) ? VECS : int'(vcount);
        acc = 0;
        if (!kmode)
        begin
            for (int d = 0; d < nd; d++)
                acc += (longint'(weight_mem[d]) * longint'(feature_mem[d])) >>> 16;
        end
        else
        begin
            for (int j = 0; j < nv; j++)
            begin
                dist2 = '0;
                for (int d = 0; d < nd; d++)
                begin
                    diff  = longint'(feature_mem[d]) - longint'(sv_mem[j*DIMS + d]);
                    mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
                    dist2 += (mag * mag) >> 16;
                end
                if (gamma_q != 0 && dist2 > 64'hFFFF_FFFF_FFFF_FFFF / 64'(gamma_q))
                    t = 64'hFFFF_FFFF_FFFF_FFFF >> 16;
                else
                    t = (64'(gamma_q) * dist2) >> 16;
                k = exp_neg_q(t);
                acc += (longint'(alpha_mem[j]) * longint'(k)) >>> 16;
            end
        end
        acc += bias_q;
        if (acc > S32_MAX) acc = S32_MAX;
        if (acc < S32_MIN) acc = S32_MIN;
        return acc;
    endfunction

    // Apply one accepted word to the shadow state; returns 1 with a result on a
    // last feature word.
    function automatic bit predict_word(input item_t w, output result_t r);
        longint f;
        r = '0;
        case (cmd_t'(w.cmd))
            CMD_WEIGHT:  weight_mem[w.dim_index] = w.value;
            CMD_SUPPORT: sv_mem[int'(w.vector_index)*DIMS + int'(w.dim_index)] = w.value;
            CMD_ALPHA:   alpha_mem[w.vector_index] = w.value;
            default:
            begin
                feature_mem[w.dim_index] = w.value;
                if (!w.last)
                    return 1'b0;
                f                = decision_value();
                r.score          = platt_score(f);
                r.label_positive = (f >= 0);
                r.decision_value = f[31:0];
                for (int d = 0; d < DIMS; d++)
                    feature_mem[d] = '0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Clock, reset, and the overall cycle limit.
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("svm_linear_rbf_predict verification failed");
            $finish;
        end
    end

    // Input monitor: every accepted word advances the shadow state; a last feature
    // word queues either the typed expectation from the table or the prediction.
    always @(posedge clk)
    begin
        offer_t  o;
        result_t r;
        if (rst_n && item_valid && item_ready)
        begin
            o = offered_words.pop_front();
            if (predict_word(item, r))
                expected_results.insert(expected_results.size(), o.typed ? o.res : r);
        end
    end

    // Output monitor: compare field by field against the oldest expectation.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.score !== e.score)
                begin
                    $display("%0t: score exp %0d got %0d", $time, e.score, result.score);
                    errors++;
                end
                if (result.label_positive !== e.label_positive)
                begin
                    $display("%0t: label exp %0d got %0d", $time,
                             e.label_positive, result.label_positive);
                    errors++;
                end
                if (result.decision_value !== e.decision_value)
                begin
                    $display("%0t: decision exp %h got %h", $time,
                             e.decision_value, result.decision_value);
                    errors++;
                end
            end
        end
    end

    // Receiver: drop ready at random, or hold it low for a long stretch on request
    // so that the block backs up and stalls its input.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word and hold it until accepted; idle first at random.
    task automatic send_word(input item_t w, input bit typed, input result_t r);
        offer_t o;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        o.typed = typed;
        o.res   = r;
        offered_words.insert(offered_words.size(), o);
        item       <= w;
        item_valid <= 1'b1;
        do @(posedge clk); while (!(item_valid && item_ready));
    endtask

    task automatic load_word(input cmd_t c, input int vi, input int di, input logic [31:0] v);
        item_t w;
        w.cmd          = c;
        w.vector_index = 6'(vi);
        w.dim_index    = 8'(di);
        w.value        = v;
        w.last         = 1'($urandom);
        if (c == CMD_FEATURE)
            w.last = 1'b0;
        send_word(w, 1'b0, '0);
    endtask

    // APB write: setup cycle, access cycle, register taken at the access edge.
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_KERNEL_MODE:     kmode    = v[0];
            REG_BIAS:            bias_q   = longint'(signed'(v));
            REG_SIGMOID_SLOPE:   slope_q  = longint'(signed'(v));
            REG_SIGMOID_OFFSET:  offset_q = longint'(signed'(v));
            REG_KERNEL_GAMMA:    gamma_q  = v[30:0];
            REG_VECTOR_COUNT:    vcount   = v[6:0];
            default:             dcount   = v[8:0];
        endcase
    endtask

    // Hold until every expected result is out and the block is back in idle
    // with its clearing sweep done.
    task automatic drain;
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || !item_ready) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 17;
                recv_idle_pct = 54;
            end
            1:
            begin
                send_idle_pct = 54;
                recv_idle_pct = 17;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    function automatic logic [31:0] rand_value;
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(524288)) - 32'd262144;
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($urandom_range(131072)) - 32'd65536;
        endcase
    endfunction

    // Write every register, preload the support rows and alphas that the
    // radial kernel will read, then run random words.
    task automatic run_phase(input bit radial, input logic [31:0] bias_v,
                             input logic [31:0] slope_v, input logic [31:0] offset_v,
                             input logic [31:0] gamma_v, input int vc, input int dc,
                             input int n_words, input int idling);
        int    nv, nd, r;
        item_t w;
        reg_write(REG_KERNEL_MODE, 32'(radial));
        reg_write(REG_BIAS, bias_v);
        reg_write(REG_SIGMOID_SLOPE, slope_v);
        reg_write(REG_SIGMOID_OFFSET, offset_v);
        reg_write(REG_KERNEL_GAMMA, gamma_v);
        reg_write(REG_VECTOR_COUNT, 32'(vc));
        reg_write(REG_DIMENSION_COUNT, 32'(dc));
        set_idling(idling);
        nv = (vc > VECS) ? VECS : vc;
        nd = (dc > DIMS) ? DIMS : dc;
        if (radial)
        begin
            for (int j = 0; j < nv; j++)
            begin
                load_word(CMD_ALPHA, j, $urandom_range(255), rand_value());
                for (int d = 0; d < nd; d++)
                    load_word(CMD_SUPPORT, j, d, rand_value());
            end
        end
        for (int i = 0; i < n_words; i++)
        begin
            r              = $urandom_range(99);
            w.vector_index = 6'($urandom);
            w.dim_index    = 8'($urandom);
            w.value        = rand_value();
            w.last         = 1'($urandom);
            if (r < (radial ? 5 : 25))
                w.cmd = CMD_WEIGHT;
            else if (r < (radial ? 15 : 32))
                w.cmd = 2'($urandom_range(1, 2));
            else
            begin
                w.cmd  = CMD_FEATURE;
                w.last = ($urandom_range(5) == 0);
                // Aim most features at the dimensions that count.
                if (nd > 0 && $urandom_range(3) != 0)
                    w.dim_index = 8'($urandom_range(nd - 1));
            end
            send_word(w, 1'b0, '0);
        end
        drain();
    endtask

    // Directed table, walked at reset configuration (linear, all zero weights).
    typedef struct {
        item_t   w;
        bit      typed;
        result_t res;
    } dir_row_t;

    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    dir_row_t dir_rows [] = '{
        // all-zero sample: f=0, z=0, score one half, positive label
        '{'{CMD_FEATURE, 6'd0, 8'd0, 32'sd0, 1'b1}, 1'b1, '{16'd32768, 1'b1, 32'sd0}},
        '{'{CMD_WEIGHT, 6'd0, 8'd0, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{CMD_WEIGHT, 6'd63, 8'd255, 32'h8000_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd0, 8'd0, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
        // both extreme products positive: decision saturates high, slope zero
        '{'{CMD_FEATURE, 6'd63, 8'd255, 32'h8000_0000, 1'b1}, 1'b1,
          '{16'd32768, 1'b1, 32'h7FFF_FFFF}},
        // last on a load word is ignored
        '{'{CMD_WEIGHT, 6'd0, 8'd1, ONE_Q, 1'b1}, 1'b0, '0},
        '{'{CMD_SUPPORT, 6'd63, 8'd255, 32'h1234_5678, 1'b1}, 1'b0, '0},
        '{'{CMD_ALPHA, 6'd63, 8'd0, 32'h8000_0000, 1'b1}, 1'b0, '0},
        '{'{CMD_SUPPORT, 6'd0, 8'd0, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{CMD_ALPHA, 6'd0, 8'd255, ONE_Q, 1'b0}, 1'b0, '0},
        // repeated index: later value replaces the earlier one
        '{'{CMD_FEATURE, 6'd0, 8'd1, 32'h0002_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd0, 8'd1, 32'h0003_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd5, 8'd200, 32'h0005_0000, 1'b1}, 1'b0, '0},
        // tiny negative feature against the largest weight: negative label
        '{'{CMD_FEATURE, 6'd0, 8'd0, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd63, 8'd255, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd0, 8'd0, 32'h8000_0000, 1'b1}, 1'b0, '0},
        '{'{CMD_FEATURE, 6'd42, 8'd128, 32'h0000_8000, 1'b1}, 1'b0, '0}
    };

    initial
    begin
        // Shadow reset: support and alpha are never read before written.
        for (int d = 0; d < DIMS; d++)
        begin
            weight_mem[d]  = '0;
            feature_mem[d] = '0;
        end
        for (int i = 0; i < VECS*DIMS; i++)
            sv_mem[i] = '0;
        for (int j = 0; j < VECS; j++)
            alpha_mem[j] = '0;
        kmode    = 1'b0;
        bias_q   = 0;
        slope_q  = 0;
        offset_q = 0;
        gamma_q  = GAMMA_RESET;
        vcount   = '0;
        dcount   = DIM_COUNT_RESET;

        // Wait out reset and the clearing sweep that follows it.
        @(posedge clk);
        while (!(rst_n && item_ready)) @(posedge clk);

        set_idling(0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
        drain();

        // Long receiver hold-off at the start of the first random phase.
        hold_cycles = 2500;
        run_phase(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  0, 256, 200, 0);
        run_phase(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  0, 0, 50, 1);
        run_phase(1'b0, $urandom_range(262144) - 131072, $urandom_range(131072) - 65536,
                  $urandom_range(131072) - 65536, $urandom, 3, $urandom_range(1, 40),
                  220, 2);
        // vector count beyond memory clamps to the full 64 rows
        run_phase(1'b1, $urandom_range(65536) - 32768, ONE_Q, 32'h0, ONE_Q,
                  127, 2, 100, 0);
        // dimension count beyond memory clamps; no vectors in use
        run_phase(1'b1, $urandom, $urandom_range(131072) - 65536, $urandom, ONE_Q,
                  0, 511, 40, 1);
        run_phase(1'b1, $urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
                  $urandom_range(131072) - 65536, 32'h7FFF_FFFF, $urandom_range(1, 8),
                  $urandom_range(1, 16), 150, 2);
        run_phase(1'b1, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 4, 1, 80, 0);
        run_phase(1'b0, $urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
                  $urandom_range(131072) - 65536, $urandom_range(65536), 0, 300, 80, 1);

        if (errors == 0 && expected_results.size() == 0)
            $display("svm_linear_rbf_predict verification clean");
        else
            $display("svm_linear_rbf_predict verification failed");
        $finish;
    end

endmodule
